@@ rtl/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LINE_CHARS = 40;
  localparam int AW = $clog2(LINE_CHARS);
  localparam int PW = 6;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [PW-1:0] LAST_POS = PW'(LINE_CHARS - 1);

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // one accepted transaction, expanded into up to three result beats
  typedef struct packed {
    logic [1:0]    n;
    logic [7:0]    byte0;
    logic [7:0]    byte1;
    logic          use_rd;
    logic          is_echo;
    logic          done;
    logic [PW-1:0] len;
    logic          flag;
  } beat_t;

endpackage

@@ rtl/sle_out_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_out_seq
// Holds one expanded transaction and plays out its result beats.
// ----------------------------------------------------------------------------
module sle_out_seq import sle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  beat_t       item_i,
  input  logic [7:0]  rdata_i,
  output logic        can_load_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // out_byte[7:0], line_done[8], line_length[14:9],
                                       // ready_flag[15]
  output logic        m_axis_tuser_o,  // is_echo
  output logic        m_axis_tlast_o
);

  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  beat_t      item_q;
  logic       last_beat;
  logic [7:0] out_byte;

  assign last_beat  = (idx_q == (item_q.n - 2'd1));
  assign can_load_o = !busy_q || (m_axis_tready_i && last_beat);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (busy_q && m_axis_tready_i) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_byte = item_q.use_rd ? rdata_i : item_q.byte0;
      2'd1:    out_byte = item_q.byte1;
      default: out_byte = CH_BS;
    endcase
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {item_q.flag, item_q.len, item_q.done, out_byte};
  assign m_axis_tuser_o  = item_q.is_echo;
  assign m_axis_tlast_o  = last_beat;

endmodule

@@ rtl/serial_line_editor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_editor_top
// Console line editor: stores received bytes in a line buffer and echoes them.
// ----------------------------------------------------------------------------
// A transaction puts one result beat on the result port for each of its results:
// one for reads, flag clears and most bytes, two for CR, three for a backspace
// that erases. The next transaction is taken while the last result goes out.
// A byte that fills the line needs two writes on the single buffer write port
// (the byte and its zero terminator), so the input pauses for the terminator write.
// The line buffer is a one-read, one-write memory with a registered read port.
module serial_line_editor_top import sle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  logic [1:0]  s_axis_tuser_i,   // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // out_byte[7:0], line_done[8], line_length[14:9],
                                        // ready_flag[15]
  output logic        m_axis_tuser_o,   // is_echo
  output logic        m_axis_tlast_o
);

  logic [7:0]    mem [LINE_CHARS];
  logic [7:0]    rdata_q;

  logic [PW-1:0] pos_q, pos_d;
  logic          ended_q, ended_d;
  logic          ready_q, ready_d;
  logic          pend_q, pend_d;
  logic [PW-1:0] pend_addr_q, pend_addr_d;

  logic          can_load, accept;
  op_e           op;
  logic [7:0]    ch;
  logic [5:0]    ridx;
  logic          rd_en, rd_in_range;
  logic          we;
  logic [PW-1:0] waddr;
  logic [7:0]    wdata;
  logic [PW-1:0] p0, p1;
  logic          done;
  beat_t         item;

  assign op   = op_e'(s_axis_tuser_i);
  assign ch   = s_axis_tdata_i[7:0];
  assign ridx = s_axis_tdata_i[13:8];

  assign s_axis_tready_o = can_load && !pend_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_in_range     = (32'(ridx) < LINE_CHARS);
  assign rd_en           = accept && (op == OP_READ);

  always_comb begin
    p0 = ended_q ? '0 : ((pos_q > LAST_POS) ? LAST_POS : pos_q);
    p1 = p0;
    item.n       = 2'd1;
    item.byte0   = ch;
    item.byte1   = CH_LF;
    item.use_rd  = 1'b0;
    item.is_echo = 1'b0;
    item.done    = 1'b0;
    item.len     = pos_q;
    item.flag    = ready_q;
    pos_d        = pos_q;
    ended_d      = ended_q;
    ready_d      = ready_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    we           = pend_q;
    waddr        = pend_addr_q;
    wdata        = CH_NUL;
    done         = 1'b0;
    if (accept) begin
      unique case (op)
        OP_RX: begin
          item.is_echo = 1'b1;
          if (ch == CH_BS) begin
            if (p0 != '0) begin
              item.n  = 2'd3;
              item.byte1 = CH_SP;
              p1      = p0 - PW'(1);
            end
          end else if (ch == CH_CR) begin
            item.n  = 2'd2;
            done    = 1'b1;
          end else if (ch == CH_LF) begin
            done    = 1'b1;
          end else begin
            p1      = p0 + PW'(1);
          end
          if (p1 >= LAST_POS) begin
            done = 1'b1;
          end
          pos_d   = p1;
          ended_d = done;
          if (done) begin
            ready_d = 1'b1;
          end
          we    = 1'b1;
          waddr = p0;
          wdata = (done && (p1 == p0)) ? CH_NUL : ch;
          if (done && (p1 != p0)) begin
            pend_d      = 1'b1;
            pend_addr_d = p1;
          end
          item.done = done;
          item.len  = p1;
          item.flag = ready_d;
        end
        OP_READ: begin
          item.use_rd = 1'b1;
        end
        OP_CLEAR: begin
          ready_d    = 1'b0;
          item.byte0 = CH_NUL;
          item.flag  = 1'b0;
        end
        default: begin
          item.byte0 = CH_NUL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ended_q <= 1'b1;
      ready_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      ended_q <= ended_d;
      ready_q <= ready_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= rd_in_range ? mem[ridx[AW-1:0]] : CH_NUL;
    end
  end

  sle_out_seq u_out_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .item_i          (item),
    .rdata_i         (rdata_q),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
